>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the kvt_out_buf module
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// condition holds at every rising clock edge outside reset
`define KVT_ASSERT(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed");

// antecedent in one cycle implies consequent in the next
`define KVT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define KVT_ASSERT(lbl, clk, rst, cond)
`define KVT_ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

>>> sv/kvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_pkg
// Types, codes and character classes of the key/value text tokenizer
// ----------------------------------------------------------------------------
package kvt_pkg;

  // parser modes
  localparam logic [2:0] MODE_KEY   = 3'd0;
  localparam logic [2:0] MODE_TAB   = 3'd1;
  localparam logic [2:0] MODE_VALUE = 3'd2;
  localparam logic [2:0] MODE_NL    = 3'd3;
  localparam logic [2:0] MODE_HALT  = 3'd4;

  // event kinds
  localparam logic [2:0] EV_KEY_BYTE = 3'd0;
  localparam logic [2:0] EV_KEY_END  = 3'd1;
  localparam logic [2:0] EV_VAL_BYTE = 3'd2;
  localparam logic [2:0] EV_VAL_END  = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;
  localparam logic [2:0] EV_CLEAN    = 3'd5;

  // error kinds
  localparam logic [2:0] ER_MISSING_EQ = 3'd0;
  localparam logic [2:0] ER_EQ_NO_KEY  = 3'd1;
  localparam logic [2:0] ER_TRAILING   = 3'd2;
  localparam logic [2:0] ER_NO_VALUE   = 3'd3;
  localparam logic [2:0] ER_INVALID    = 3'd4;

  // characters
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NONE  = 8'h00;

  // most events one byte can cause
  localparam int unsigned MAX_EVENTS = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       start_of_file;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0] event_kind;
    logic [7:0] byte_out;
    logic [2:0] error_kind;
    logic       last_of_run;
  } out_item_t;

  // one event before the run marker is attached
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic [2:0] err;
  } ev_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       key_started;
    logic       blank_after_key;
    logic       equals_seen;
  } parse_state_t;

  localparam parse_state_t STATE_RESET = '{
    mode: MODE_KEY, key_started: 1'b0, blank_after_key: 1'b0, equals_seen: 1'b0};

  function automatic ev_t make_ev(logic [2:0] kind, logic [7:0] data, logic [2:0] err);
    ev_t e;
    e.kind = kind;
    e.data = data;
    e.err  = err;
    return e;
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return (c == CH_TAB) || (c == CH_SPACE);
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_key_char(logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           ((c >= 8'h61) && (c <= 8'h7A)) || (c == CH_UNDER) || (c == CH_DASH);
  endfunction

endpackage

>>> sv/kvt_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_step
// Next parser state and the up to three events caused by one input byte
// ----------------------------------------------------------------------------
module kvt_step (
  input  kvt_pkg::parse_state_t state,
  input  kvt_pkg::in_item_t     item,
  output kvt_pkg::parse_state_t state_next,
  output kvt_pkg::ev_t          events [kvt_pkg::MAX_EVENTS],
  output logic [1:0]            event_count
);
  import kvt_pkg::*;

  logic [7:0]   c;
  parse_state_t s;
  logic [1:0]   n;
  logic         do_key_line;

  assign c = item.data_byte;

  always_comb begin
    s           = item.start_of_file ? STATE_RESET : state;
    n           = 2'd0;
    do_key_line = 1'b0;
    for (int i = 0; i < MAX_EVENTS; i++) begin
      events[i] = make_ev(EV_CLEAN, CH_NONE, ER_MISSING_EQ);
    end

    // per-mode handling of the byte
    unique case (s.mode)
      MODE_KEY: begin
        do_key_line = 1'b1;
      end
      MODE_TAB: begin
        if (c == CH_TAB) begin
          events[n] = make_ev(EV_KEY_END, CH_NONE, ER_MISSING_EQ);
          n = n + 2'd1;
          s = STATE_RESET;
          s.mode = MODE_VALUE;
        end else begin
          events[n] = make_ev(EV_ERROR, CH_NONE, ER_NO_VALUE);
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
      end
      MODE_VALUE: begin
        if (c == CH_NL) begin
          s.mode = MODE_NL;
        end else begin
          events[n] = make_ev(EV_VAL_BYTE, c, ER_MISSING_EQ);
          n = n + 2'd1;
        end
      end
      MODE_NL: begin
        if (c == CH_TAB) begin
          events[n] = make_ev(EV_VAL_BYTE, CH_NL, ER_MISSING_EQ);
          n = n + 2'd1;
          s.mode = MODE_VALUE;
        end else if (c == CH_PLUS) begin
          s.mode = MODE_VALUE;
        end else begin
          // value ends, this byte opens the next key line
          events[n] = make_ev(EV_VAL_END, CH_NONE, ER_MISSING_EQ);
          n = n + 2'd1;
          s = STATE_RESET;
          do_key_line = 1'b1;
        end
      end
      default: begin
        s.mode = MODE_HALT;
      end
    endcase

    // key line byte
    if (do_key_line) begin
      if (c == CH_NL) begin
        if (s.equals_seen) begin
          s.mode = MODE_TAB;
        end else if (s.key_started) begin
          events[n] = make_ev(EV_ERROR, CH_NONE, ER_MISSING_EQ);
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
      end else if (c == CH_EQ) begin
        s.blank_after_key = 1'b0;
        s.equals_seen     = 1'b1;
        if (!s.key_started) begin
          events[n] = make_ev(EV_ERROR, CH_NONE, ER_EQ_NO_KEY);
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
      end else if (s.blank_after_key && !is_blank(c)) begin
        events[n] = make_ev(EV_ERROR, CH_NONE, ER_MISSING_EQ);
        n = n + 2'd1;
        s.mode = MODE_HALT;
      end else if (s.equals_seen && !is_blank(c)) begin
        events[n] = make_ev(EV_ERROR, CH_NONE, ER_TRAILING);
        n = n + 2'd1;
        s.mode = MODE_HALT;
      end else if (s.key_started && is_blank(c) && !s.equals_seen) begin
        s.blank_after_key = 1'b1;
      end else if (is_space(c)) begin
        // white space skipped
      end else if (!is_key_char(c)) begin
        events[n] = make_ev(EV_ERROR, CH_NONE, ER_INVALID);
        n = n + 2'd1;
        s.mode = MODE_HALT;
      end else begin
        s.key_started = 1'b1;
        events[n] = make_ev(EV_KEY_BYTE, c, ER_MISSING_EQ);
        n = n + 2'd1;
      end
    end

    // end of input
    if (item.end_of_file) begin
      case (s.mode)
        MODE_KEY: begin
          if (s.equals_seen) begin
            events[n] = make_ev(EV_ERROR, CH_NONE, ER_NO_VALUE);
          end else if (s.blank_after_key || s.key_started) begin
            events[n] = make_ev(EV_ERROR, CH_NONE, ER_MISSING_EQ);
          end else begin
            events[n] = make_ev(EV_CLEAN, CH_NONE, ER_MISSING_EQ);
          end
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
        MODE_TAB: begin
          events[n] = make_ev(EV_ERROR, CH_NONE, ER_NO_VALUE);
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
        MODE_VALUE, MODE_NL: begin
          events[n] = make_ev(EV_VAL_END, CH_NONE, ER_MISSING_EQ);
          n = n + 2'd1;
          events[n] = make_ev(EV_CLEAN, CH_NONE, ER_MISSING_EQ);
          n = n + 2'd1;
          s.mode = MODE_HALT;
        end
        default: begin
        end
      endcase
    end
  end

  assign state_next  = s;
  assign event_count = n;

endmodule

>>> sv/kvt_out_buf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// kvt_out_buf
// Holds the events of one byte and hands them out one item per cycle while event_ready is high
// ----------------------------------------------------------------------------
module kvt_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  kvt_pkg::ev_t        events [kvt_pkg::MAX_EVENTS],
  input  logic [1:0]          event_count,
  output logic                can_load,
  output logic                event_valid,
  input  logic                event_ready,
  output kvt_pkg::out_item_t  event_item
);
  import kvt_pkg::*;

  ev_t        grp [MAX_EVENTS];
  logic [1:0] grp_count;
  logic [1:0] grp_ptr;
  logic       grp_valid;
  logic       at_last;
  logic       pop;

  assign at_last  = (grp_ptr == grp_count - 2'd1);
  assign pop      = grp_valid && event_ready;
  assign can_load = !grp_valid || (pop && at_last);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      grp_ptr   <= 2'd0;
      grp_count <= 2'd0;
    end else if (load && can_load && (event_count != 2'd0)) begin
      grp_valid <= 1'b1;
      grp_ptr   <= 2'd0;
      grp_count <= event_count;
    end else if (pop) begin
      if (at_last) begin
        grp_valid <= 1'b0;
      end else begin
        grp_ptr <= grp_ptr + 2'd1;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && can_load) begin
      grp <= events;
    end
  end

  // output selection
  always_comb begin
    event_item.event_kind  = grp[grp_ptr].kind;
    event_item.byte_out    = grp[grp_ptr].data;
    event_item.error_kind  = grp[grp_ptr].err;
    event_item.last_of_run = at_last;
  end
  assign event_valid = grp_valid;

`include "assert_macros.svh"

  `KVT_ASSERT(a_count_nonzero, clk, rst, !grp_valid || (grp_count != 2'd0))
  `KVT_ASSERT(a_ptr_in_group, clk, rst, !grp_valid || (grp_ptr < grp_count))
  `KVT_ASSERT_NEXT(a_group_continues, clk, rst, pop && !at_last, grp_valid && (grp_ptr != 2'd0))

endmodule

>>> sv/key_value_text_tokenizer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_value_text_tokenizer_top
// Byte stream tokenizer for key lines with tab-indented value lines
// ----------------------------------------------------------------------------
// One text byte is taken per cycle, while byte_ready is high, into an input
// register; from there the parser state and the byte's events (none to
// three) are decoded into an event group register that hands out one event
// item per cycle while event_ready is high. A byte that causes several
// events holds the event port until the last is taken, as there is a
// single event output. A byte's first event leaves the event group register
// after the byte has passed the input register. The input register takes
// one more byte while the event port is stalled. An error or clean end
// halts the parser until a byte with start_of_file set arrives.
module key_value_text_tokenizer_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                byte_valid,
  output logic                byte_ready,
  input  kvt_pkg::in_item_t   byte_item,
  output logic                event_valid,
  input  logic                event_ready,
  output kvt_pkg::out_item_t  event_item
);
  import kvt_pkg::*;

  in_item_t     in_reg;
  logic         in_full;
  parse_state_t state;
  parse_state_t state_next;
  ev_t          events [MAX_EVENTS];
  logic [1:0]   event_count;
  logic         can_load;
  logic         move;

  assign move       = in_full && can_load;
  assign byte_ready = !in_full || move;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (byte_valid && byte_ready) begin
      in_full <= 1'b1;
    end else if (move) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && byte_ready) begin
      in_reg <= byte_item;
    end
  end

  // parser state advances as each item is decoded
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (move) begin
      state <= state_next;
    end
  end

  kvt_step u_step (
    .state       (state),
    .item        (in_reg),
    .state_next  (state_next),
    .events      (events),
    .event_count (event_count)
  );

  kvt_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (move),
    .events      (events),
    .event_count (event_count),
    .can_load    (can_load),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_item  (event_item)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the key/value text tokenizer: short texts aimed at
// each token and each error kind, then random texts, mostly well formed with
// some bytes corrupted, sent under four idling patterns. Every text byte is
// run through a local token predictor, and each event item from the block is
// compared with the oldest predicted token.
// ----------------------------------------------------------------------------
module tb;
  import kvt_pkg::*;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      byte_valid = 1'b0;
  logic      byte_ready;
  in_item_t  byte_item = '0;
  logic      event_valid;
  logic      event_ready = 1'b0;
  out_item_t event_item;

  key_value_text_tokenizer_top u_top (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_valid),
    .byte_ready  (byte_ready),
    .byte_item   (byte_item),
    .event_valid (event_valid),
    .event_ready (event_ready),
    .event_item  (event_item)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int fail_count = 0;
  int mismatch_count = 0;
  int live_bytes = 0;

  // tokenizer state as the predictor sees it
  logic [2:0] scan_mode = MODE_KEY;
  bit         seen_key = 1'b0;
  bit         seen_gap = 1'b0;
  bit         seen_equals = 1'b0;

  out_item_t  step_tokens[$];
  out_item_t  expected_tokens[$];

  // ---------------------------------------------------------------------------
  // token predictor
  // ---------------------------------------------------------------------------

  function automatic bit blank_char(logic [7:0] c);
    return c == CH_TAB || c == CH_SPACE;
  endfunction

  function automatic bit name_char(logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
           (c >= "a" && c <= "z") || c == CH_UNDER || c == CH_DASH;
  endfunction

  function automatic void push_token(logic [2:0] kind, logic [7:0] data,
                                     logic [2:0] err);
    out_item_t t;
    t.event_kind  = kind;
    t.byte_out    = data;
    t.error_kind  = err;
    t.last_of_run = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void stop_with(logic [2:0] err);
    push_token(EV_ERROR, CH_NONE, err);
    scan_mode = MODE_HALT;
  endfunction

  function automatic void clear_key_line();
    seen_key    = 1'b0;
    seen_gap    = 1'b0;
    seen_equals = 1'b0;
  endfunction

  // one byte on a key line, in priority order
  function automatic void scan_key_line(logic [7:0] c);
    if (c == CH_NL) begin
      if (seen_equals) scan_mode = MODE_TAB;
      else if (seen_key) stop_with(ER_MISSING_EQ);
    end else if (c == CH_EQ) begin
      seen_gap    = 1'b0;
      seen_equals = 1'b1;
      if (!seen_key) stop_with(ER_EQ_NO_KEY);
    end else if (seen_gap && !blank_char(c)) begin
      stop_with(ER_MISSING_EQ);
    end else if (seen_equals && !blank_char(c)) begin
      stop_with(ER_TRAILING);
    end else if (seen_key && blank_char(c) && !seen_equals) begin
      seen_gap = 1'b1;
    end else if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
      // white space skipped
    end else if (!name_char(c)) begin
      stop_with(ER_INVALID);
    end else begin
      seen_key = 1'b1;
      push_token(EV_KEY_BYTE, c, 3'd0);
    end
  endfunction

  // end of text closes whatever is open
  function automatic void finish_text();
    case (scan_mode)
      MODE_KEY: begin
        if (seen_equals) stop_with(ER_NO_VALUE);
        else if (seen_gap || seen_key) stop_with(ER_MISSING_EQ);
        else begin
          push_token(EV_CLEAN, CH_NONE, 3'd0);
          scan_mode = MODE_HALT;
        end
      end
      MODE_TAB: stop_with(ER_NO_VALUE);
      MODE_VALUE, MODE_NL: begin
        push_token(EV_VAL_END, CH_NONE, 3'd0);
        push_token(EV_CLEAN, CH_NONE, 3'd0);
        scan_mode = MODE_HALT;
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_tokens(in_item_t it);
    logic [7:0] c;
    c = it.data_byte;
    step_tokens.delete();
    if (it.start_of_file) begin
      scan_mode = MODE_KEY;
      clear_key_line();
    end
    if (scan_mode != MODE_HALT) live_bytes++;
    case (scan_mode)
      MODE_KEY: scan_key_line(c);
      MODE_TAB: begin
        if (c == CH_TAB) begin
          push_token(EV_KEY_END, CH_NONE, 3'd0);
          clear_key_line();
          scan_mode = MODE_VALUE;
        end else begin
          stop_with(ER_NO_VALUE);
        end
      end
      MODE_VALUE: begin
        if (c == CH_NL) scan_mode = MODE_NL;
        else push_token(EV_VAL_BYTE, c, 3'd0);
      end
      MODE_NL: begin
        if (c == CH_TAB) begin
          push_token(EV_VAL_BYTE, CH_NL, 3'd0);
          scan_mode = MODE_VALUE;
        end else if (c == CH_PLUS) begin
          scan_mode = MODE_VALUE;
        end else begin
          push_token(EV_VAL_END, CH_NONE, 3'd0);
          clear_key_line();
          scan_mode = MODE_KEY;
          scan_key_line(c);
        end
      end
      default: ;
    endcase
    if (it.end_of_file) finish_text();
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last_of_run = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // event side: random stall and checking
  // ---------------------------------------------------------------------------

  always @(negedge clk) begin
    event_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && event_valid && event_ready) begin
      if (expected_tokens.size() == 0) begin
        fail_count++;
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected event: kind %0d byte %02h err %0d last %0b",
                   event_item.event_kind, event_item.byte_out,
                   event_item.error_kind, event_item.last_of_run);
      end else begin
        want = expected_tokens.pop_front();
        if (event_item.event_kind !== want.event_kind ||
            event_item.byte_out !== want.byte_out ||
            event_item.error_kind !== want.error_kind ||
            event_item.last_of_run !== want.last_of_run) begin
          fail_count++;
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("event mismatch: expected kind %0d byte %02h err %0d last %0b, got kind %0d byte %02h err %0d last %0b",
                     want.event_kind, want.byte_out, want.error_kind, want.last_of_run,
                     event_item.event_kind, event_item.byte_out,
                     event_item.error_kind, event_item.last_of_run);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // byte side
  // ---------------------------------------------------------------------------

  // send one text byte, valid held until taken
  task automatic send_byte(logic [7:0] c, bit sof, bit eof);
    in_item_t it;
    it.data_byte     = c;
    it.start_of_file = sof;
    it.end_of_file   = eof;
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_valid <= 1'b0;
      @(negedge clk);
    end
    byte_valid <= 1'b1;
    byte_item  <= it;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    predict_tokens(it);
  endtask

  // a whole text, start flagged on the first byte
  task automatic send_text(string s, bit eof_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], i == 0, eof_last && i == s.len() - 1);
  endtask

  function automatic logic [7:0] rand_name_char();
    int r;
    r = $urandom_range(63);
    if (r < 10) return 8'("0" + r);
    if (r < 36) return 8'("A" + r - 10);
    if (r < 62) return 8'("a" + r - 36);
    return (r == 62) ? CH_UNDER : CH_DASH;
  endfunction

  function automatic logic [7:0] rand_value_char();
    logic [7:0] c;
    if ($urandom_range(3) != 0) return 8'($urandom_range(8'h7E, 8'h21));
    c = 8'($urandom_range(255));
    return (c == CH_NL) ? CH_SPACE : c;
  endfunction

  // one random text: mostly well-formed entries, sometimes corrupted
  task automatic send_random_text();
    logic [7:0] text[$];
    int entries;
    int lines;
    int pos;
    bit eof_last;
    entries = $urandom_range(3, 1);
    for (int e = 0; e < entries; e++) begin
      if ($urandom_range(5) == 0) text.push_back(CH_NL);
      if ($urandom_range(5) == 0) text.push_back(CH_SPACE);
      repeat ($urandom_range(4, 1)) text.push_back(rand_name_char());
      repeat ($urandom_range(2)) text.push_back($urandom_range(1) ? CH_TAB : CH_SPACE);
      text.push_back(CH_EQ);
      if ($urandom_range(4) == 0) text.push_back(CH_SPACE);
      text.push_back(CH_NL);
      text.push_back(CH_TAB);
      repeat ($urandom_range(3)) text.push_back(rand_value_char());
      lines = $urandom_range(2);
      repeat (lines) begin
        text.push_back(CH_NL);
        text.push_back($urandom_range(1) ? CH_TAB : CH_PLUS);
        repeat ($urandom_range(3)) text.push_back(rand_value_char());
      end
      if (e < entries - 1 || $urandom_range(1)) text.push_back(CH_NL);
    end
    // corruption: overwrite one byte or cut the text short
    if ($urandom_range(3) == 0) begin
      pos = $urandom_range(text.size() - 1);
      text[pos] = 8'($urandom_range(255));
    end else if ($urandom_range(7) == 0) begin
      pos = $urandom_range(text.size() - 1, 1);
      while (text.size() > pos) void'(text.pop_back());
    end
    eof_last = ($urandom_range(7) != 0);
    foreach (text[i])
      send_byte(text[i], i == 0, eof_last && i == text.size() - 1);
    // stray bytes after the end, without a new start
    if ($urandom_range(3) == 0)
      repeat ($urandom_range(2, 1)) send_byte(8'($urandom_range(255)), 1'b0, 1'b0);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // key bytes, blanks before '=', key end, value lines, join and clean end
  task automatic test_key_and_value();
    send_text("a_Z-9 =\n\tv\n\t\n+x", 1'b1);
  endtask

  // error kinds raised by a byte: missing '=', '=' without a key, trailing text, invalid byte
  task automatic test_error_kinds();
    send_text("k\n", 1'b0);
    send_text("=", 1'b0);
    send_text("k=b", 1'b0);
    send_byte(8'hFF, 1'b1, 1'b0);
    send_byte("x", 1'b0, 1'b0);
  endtask

  // end of text while waiting for the value, and on an empty text
  task automatic test_end_of_text();
    send_text("k=\n", 1'b1);
    send_text("\n", 1'b1);
  endtask

  task automatic test_random_traffic();
    int idle_set[4];
    int stall_set[4];
    idle_set  = '{0, 50, 0, 37};
    stall_set = '{0, 0, 50, 37};
    for (int p = 0; p < 4; p++) begin
      sender_idle_pct    = idle_set[p];
      receiver_stall_pct = stall_set[p];
      live_bytes = 0;
      while (live_bytes < 20) send_random_text();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_key_and_value();
    test_error_kinds();
    test_end_of_text();
    test_random_traffic();

    @(negedge clk);
    byte_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);

    if (fail_count == 0) begin
      $display("PASS key_value_text_tokenizer_top");
    end else begin
      $display("FAIL key_value_text_tokenizer_top");
    end
    $finish;
  end

  // run limit
  initial begin
    #2000000;
    $display("FAIL key_value_text_tokenizer_top");
    $finish;
  end

endmodule

>>> key_value_text_tokenizer_top.f
+incdir+sv
sv/kvt_pkg.sv
sv/kvt_step.sv
sv/kvt_out_buf.sv
sv/key_value_text_tokenizer_top.sv
bench/tb.sv
